FILE: hdl/sha512_pkg.sv
// sha-512 package: round constants, initial hash words, state encoding
// and the small functions used by the core and the round unit
// no dependencies
package sha512_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    // what the padding sequencer pushes next
    typedef enum logic [1:0] {
        PAD_ZERO,
        PAD_MARK,
        PAD_LEN_HI,
        PAD_LEN_LO
    } pad_sel_t;

    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam logic [3:0]  LEN_SLOT    = 4'd14;
    localparam logic [3:0]  FULL_BYTES  = 4'd8;
    localparam logic [63:0] PAD_WORD    = 64'h8000_0000_0000_0000;

    // control group from the sequencer to the round unit
    typedef struct packed {
        logic       load;   // copy chain into working vars
        logic       step;   // run one round
        logic [6:0] round;  // current round index
    } rnd_ctrl_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] init_word(input logic [2:0] i);
        unique case (i)
            3'd0: init_word = 64'h6a09e667f3bcc908;
            3'd1: init_word = 64'hbb67ae8584caa73b;
            3'd2: init_word = 64'h3c6ef372fe94f82b;
            3'd3: init_word = 64'ha54ff53a5f1d36f1;
            3'd4: init_word = 64'h510e527fade682d1;
            3'd5: init_word = 64'h9b05688c2b3e6c1f;
            3'd6: init_word = 64'h1f83d9abfb41bd6b;
            default: init_word = 64'h5be0cd19137e2179;
        endcase
    endfunction

    localparam logic [63:0] K_TAB [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

FILE: hdl/sha512_round.sv
// sha-512 round unit: schedule ring plus working variables a..h,
// one compression round per step
// depends on sha512_pkg
module sha512_round
    import sha512_pkg::*;
(
    input  logic         aclk,
    input  rnd_ctrl_t    ctrl,
    input  logic         wr_en,       // message word write into the ring
    input  logic [3:0]   wr_addr,
    input  logic [63:0]  wr_data,
    input  logic [511:0] chain,       // chaining value, word 0 in low bits
    output logic [511:0] vars         // working vars a..h, a in low bits
);

    logic [63:0] ring_reg [0:15];
    logic [63:0] v_reg    [0:7];
    logic [63:0] v_next   [0:7];

    logic [3:0]  t_idx, i2, i7, i15;
    logic [63:0] x2, x15, d0, d1, w_new, w;
    logic [63:0] s0, s1, ch, mj, t1, t2;

    // schedule expansion for rounds 16 and up
    always_comb begin
        t_idx = ctrl.round[3:0];
        i2    = t_idx - 4'd2;
        i7    = t_idx - 4'd7;
        i15   = t_idx - 4'd15;
        x2    = ring_reg[i2];
        x15   = ring_reg[i15];
        d1    = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
        d0    = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
        w_new = d1 + ring_reg[i7] + d0 + ring_reg[t_idx];
        w     = (ctrl.round >= 7'(BLOCK_WORDS)) ? w_new : ring_reg[t_idx];
    end

    // one compression round
    always_comb begin
        s1 = rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + K_TAB[ctrl.round] + w;
        s0 = rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
    end

    // ring and working variable registers
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_reg[wr_addr] <= wr_data;
        end else if (ctrl.step && ctrl.round >= 7'(BLOCK_WORDS)) begin
            ring_reg[t_idx] <= w_new;
        end
        for (int i = 0; i < 8; i++) begin
            if (ctrl.load) begin
                v_reg[i] <= chain[i*64 +: 64];
            end else if (ctrl.step) begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            vars[i*64 +: 64] = v_reg[i];
        end
    end

endmodule

FILE: hdl/sha512_hash_core.sv
// sha-512 digest engine top level: input handshake, block gathering,
// padding sequencer, chaining value and digest output
// depends on sha512_pkg and sha512_round
//
// channel | dir | tdata                      | tuser          | tlast
// s_      | in  | data_word[63:0]            | byte_count[3:0]| last_word
// m_      | out | digest_word[63:0]          | digest_index   | digest_last
//
// a word that fills a block loads the working vars and starts the 80 rounds
// on the shared round unit, then the fold; other words are just written into the ring
// a last word pushes up to two blocks of padding, then the eight digest
// words, each held until m_tready
// s_tready is low while rounds, fold, padding or digest output are in progress
// aresetn is synchronous active low and restores the initial hash value
module sha512_hash_core
    import sha512_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // data_word[63:0]
    input  logic [3:0]  s_tuser,   // byte_count[3:0]
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic [2:0]  m_tuser,   // digest_index[2:0]
    output logic        m_tlast    // digest_last
);

    sha_state_t  state_reg, state_next;
    logic [3:0]  pos_reg;
    logic [6:0]  round_reg;
    logic [127:0] len_reg;
    logic [63:0] chain_reg [0:7];
    logic        padding_reg;   // block in progress belongs to padding
    logic        mark_done_reg; // pad mark word already pushed
    logic        lenw_reg;      // 0: high length word next, 1: low
    logic [2:0]  out_idx_reg;

    // length words pushed: tracked for the fold decision
    logic        len_done_reg;
    logic        len_done;

    logic        s_fire, m_fire;
    logic        push;
    logic [63:0] push_data;
    logic [3:0]  cnt;
    logic [63:0] mask, last_word;
    pad_sel_t    pad_sel;
    logic [511:0] chain_flat, vars;
    rnd_ctrl_t   ctrl;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign len_done = len_done_reg;

    // clamp the byte count and build the masked, marked last word
    always_comb begin
        cnt       = (s_tuser > FULL_BYTES) ? FULL_BYTES : s_tuser;
        mask      = ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt, 3'b000});
        last_word = (s_tdata & mask) | (64'h80 << (7'd56 - {cnt, 3'b000}));
    end

    // padding word selection
    always_comb begin
        priority if (!mark_done_reg)     pad_sel = PAD_MARK;
        else if (pos_reg == LEN_SLOT)    pad_sel = PAD_LEN_HI;
        else if (lenw_reg)               pad_sel = PAD_LEN_LO;
        else                             pad_sel = PAD_ZERO;
    end

    // word written into the schedule ring
    always_comb begin
        push      = 1'b0;
        push_data = s_tdata;
        if (state_reg == ST_IDLE && s_fire) begin
            push      = 1'b1;
            push_data = (s_tlast && cnt != FULL_BYTES) ? last_word : s_tdata;
        end else if (state_reg == ST_PAD) begin
            push = 1'b1;
            unique case (pad_sel)
                PAD_MARK:   push_data = PAD_WORD;
                PAD_LEN_HI: push_data = len_reg[127:64];
                PAD_LEN_LO: push_data = len_reg[63:0];
                default:    push_data = '0;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (pos_reg == 4'd15)  state_next = ST_ROUND;
                    else if (s_tlast)      state_next = ST_PAD;
                end
            end
            ST_ROUND: begin
                if (round_reg == 7'(ROUNDS - 1)) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                if (!padding_reg)                          state_next = ST_IDLE;
                else if (mark_done_reg && lenw_reg == 1'b0 && pos_reg == 4'd0
                         && len_done)                      state_next = ST_EMIT;
                else                                       state_next = ST_PAD;
            end
            ST_PAD: begin
                if (pos_reg == 4'd15) state_next = ST_ROUND;
            end
            ST_EMIT: begin
                if (m_fire && out_idx_reg == 3'd7) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid   = (state_reg == ST_EMIT);
        ctrl.load  = (state_next == ST_ROUND) && (state_reg != ST_ROUND);
        ctrl.step  = (state_reg == ST_ROUND);
        ctrl.round = round_reg;
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            chain_flat[i*64 +: 64] = chain_reg[i];
        end
    end

    sha512_round u_round (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .wr_en   (push),
        .wr_addr (pos_reg),
        .wr_data (push_data),
        .chain   (chain_flat),
        .vars    (vars)
    );

    assign m_tdata = chain_reg[out_idx_reg];
    assign m_tuser = out_idx_reg;
    assign m_tlast = (out_idx_reg == 3'd7);

    // control and chaining registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            round_reg     <= '0;
            len_reg       <= '0;
            padding_reg   <= 1'b0;
            mark_done_reg <= 1'b0;
            lenw_reg      <= 1'b0;
            len_done_reg  <= 1'b0;
            out_idx_reg   <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= init_word(3'(i));
        end else begin
            state_reg <= state_next;
            if (push) pos_reg <= pos_reg + 4'd1;

            // bit count on accepted words
            if (s_fire) begin
                len_reg <= len_reg + (s_tlast ? 128'({cnt, 3'b000}) : 128'd64);
                if (s_tlast) begin
                    padding_reg   <= 1'b1;
                    mark_done_reg <= (cnt != FULL_BYTES);
                end
            end

            if (state_reg == ST_PAD) begin
                unique case (pad_sel)
                    PAD_MARK:   mark_done_reg <= 1'b1;
                    PAD_LEN_HI: lenw_reg      <= 1'b1;
                    PAD_LEN_LO: begin
                        lenw_reg     <= 1'b0;
                        len_done_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (state_reg == ST_ROUND) begin
                round_reg <= (round_reg == 7'(ROUNDS - 1)) ? 7'd0 : round_reg + 7'd1;
            end

            // fold working vars into the chaining value
            if (state_reg == ST_FOLD) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + vars[i*64 +: 64];
                end
            end

            if (state_reg == ST_EMIT && m_fire) begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7) begin
                    pos_reg       <= '0;
                    len_reg       <= '0;
                    padding_reg   <= 1'b0;
                    mark_done_reg <= 1'b0;
                    lenw_reg      <= 1'b0;
                    len_done_reg  <= 1'b0;
                    for (int i = 0; i < 8; i++) chain_reg[i] <= init_word(3'(i));
                end
            end
        end
    end

    // no input taken while a digest is pending
    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !s_tready)
        else $error("input accepted during digest output");

    // rounds always start from round zero
    a_round_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_ROUND) |-> (round_reg == 7'd0))
        else $error("round counter not cleared at block start");

    // a block starts compressing only when all sixteen words are in
    a_block_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_ROUND) |-> (pos_reg == 4'd0))
        else $error("compression started on partial block");

    // the digest index advances by one per output transaction
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !m_tlast) |=> (out_idx_reg == $past(out_idx_reg) + 3'd1))
        else $error("digest index skipped");

endmodule
